### rtl/one_lane_bridge_arbiter_core_assert.svh
// ----------------------------------------------------------------------------
// One-lane bridge arbiter assertion macros
// Shorthand for the clocked, reset-qualified checks used in the arbiter RTL.
// ----------------------------------------------------------------------------
`ifndef ONE_LANE_BRIDGE_ARBITER_CORE_ASSERT_SVH
`define ONE_LANE_BRIDGE_ARBITER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OLBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/olba_pkg.sv
// ----------------------------------------------------------------------------
// One-lane bridge arbiter package
// Shared codes, limits and the structs that travel between the arbiter blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package olba_pkg;

  localparam int CNT_W = 8;
  localparam int DIR_W = 2;

  // Direction codes. Code 3 never appears and is read as no direction.
  localparam logic [DIR_W-1:0] DIR_LR   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RL   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd2;

  // Request type codes.
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_LEAVE  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX     = 8'hFF;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd2;

  // Channel capacity, clipped to what the transit counter can hold.
  localparam int MAX_USERS = 255;
  localparam logic [CNT_W-1:0] CAP_USERS =
    (MAX_USERS > 255) ? CNT_MAX : CNT_W'(MAX_USERS);

  typedef struct packed {
    logic [DIR_W-1:0]            dir;
    logic [CNT_W-1:0]            transit;
    logic [1:0][CNT_W-1:0]       waiting;
    logic [CNT_W-1:0]            run;
  } arb_state_t;

  typedef struct packed {
    logic req_type;
    logic side;
  } event_t;

  typedef struct packed {
    logic             granted_side;
    logic [CNT_W-1:0] granted_count;
    logic [DIR_W-1:0] direction;
    logic [CNT_W-1:0] in_transit;
    logic             error;
  } result_t;

endpackage

`default_nettype wire

### rtl/olba_in_reg.sv
// ----------------------------------------------------------------------------
// One-lane bridge arbiter input register
// Holds one accepted event until the step logic consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module olba_in_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 in_req_type,
  input  wire                 in_side,
  input  wire                 take,
  output logic                ev_valid,
  output olba_pkg::event_t    ev
);

  logic             valid_r;
  olba_pkg::event_t ev_r;

  // A new word can enter whenever the held one leaves in the same cycle.
  assign in_ready = !valid_r || take;
  assign ev_valid = valid_r;
  assign ev       = ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r.req_type <= in_req_type;
      ev_r.side     <= in_side;
    end
  end

endmodule

`default_nettype wire

### rtl/olba_step.sv
// ----------------------------------------------------------------------------
// One-lane bridge arbiter step logic
// Applies one event to the arbiter state and admits eligible waiters of one side.
// ----------------------------------------------------------------------------
`default_nettype none

module olba_step (
  input  olba_pkg::arb_state_t           st,
  input  wire [olba_pkg::CNT_W-1:0]      limit,
  input  olba_pkg::event_t               ev,
  output olba_pkg::arb_state_t           st_nxt,
  output olba_pkg::result_t              res
);

  // Waiters of one side that may enter now, bounded by the run budget when
  // the other side waits and by the free room on the channel.
  function automatic logic [olba_pkg::CNT_W-1:0] admit_count(
    input logic [olba_pkg::CNT_W-1:0] own,
    input logic [olba_pkg::CNT_W-1:0] other,
    input logic [olba_pkg::CNT_W-1:0] run_eff,
    input logic [olba_pkg::CNT_W-1:0] lim,
    input logic [olba_pkg::CNT_W-1:0] transit
  );
    logic [olba_pkg::CNT_W-1:0] cnt;
    logic [olba_pkg::CNT_W-1:0] room_run;
    logic [olba_pkg::CNT_W-1:0] room_cap;
    room_run = (lim > run_eff) ? lim - run_eff : '0;
    room_cap = (olba_pkg::CAP_USERS > transit) ? olba_pkg::CAP_USERS - transit : '0;
    cnt = own;
    if ((other != '0) && (room_run < cnt)) cnt = room_run;
    if (room_cap < cnt) cnt = room_cap;
    return cnt;
  endfunction

  logic [olba_pkg::CNT_W-1:0] lim;
  logic                       leave;
  logic                       s;
  logic                       o;
  logic [olba_pkg::CNT_W-1:0] w_s;
  logic [olba_pkg::CNT_W-1:0] w_o;
  logic                       err;
  logic                       emptied;
  olba_pkg::arb_state_t       mid;
  logic                       mid_none;
  logic                       first;
  logic [olba_pkg::CNT_W-1:0] run_eff;
  logic [olba_pkg::CNT_W-1:0] cnt_first;
  logic [olba_pkg::CNT_W-1:0] cnt_second;
  logic [olba_pkg::CNT_W-1:0] gcount;
  logic                       gside;
  logic [olba_pkg::CNT_W:0]   run_sum;

  always_comb begin
    lim   = (limit == '0) ? olba_pkg::CNT_W'(1) : limit;
    leave = (ev.req_type == olba_pkg::REQ_LEAVE);
    s     = ev.side;
    o     = !ev.side;
    w_s   = st.waiting[s];
    w_o   = st.waiting[o];

    err = leave ? (st.transit == '0) : (w_s == olba_pkg::CNT_MAX);

    // Apply the event itself.
    mid = st;
    if (st.dir[1]) begin
      mid.dir = olba_pkg::DIR_NONE;
    end
    emptied = 1'b0;
    if (!err) begin
      if (leave) begin
        mid.transit = st.transit - olba_pkg::CNT_W'(1);
        emptied     = (st.transit == olba_pkg::CNT_W'(1));
      end else begin
        mid.waiting[s] = w_s + olba_pkg::CNT_W'(1);
      end
    end
    if (emptied) begin
      if (w_o != '0) begin
        mid.dir = {1'b0, o};
        mid.run = '0;
      end else if (w_s == '0) begin
        mid.dir = olba_pkg::DIR_NONE;
        mid.run = '0;
      end
    end

    // Admission: the current direction, or with no direction the event's
    // side first and then the other side.
    mid_none = mid.dir[1];
    first    = mid_none ? s : mid.dir[0];
    run_eff  = mid_none ? '0 : mid.run;
    cnt_first  = admit_count(mid.waiting[first], mid.waiting[!first], run_eff, lim,
                             mid.transit);
    cnt_second = admit_count(mid.waiting[!first], mid.waiting[first], '0, lim,
                             mid.transit);

    if (err) begin
      gcount = '0;
      gside  = 1'b0;
    end else if (cnt_first != '0) begin
      gcount = cnt_first;
      gside  = first;
    end else if (mid_none && (cnt_second != '0)) begin
      gcount = cnt_second;
      gside  = !first;
    end else begin
      gcount = '0;
      gside  = 1'b0;
    end

    run_sum = {1'b0, run_eff} + {1'b0, gcount};
    st_nxt  = mid;
    if (gcount != '0) begin
      st_nxt.waiting[gside] = mid.waiting[gside] - gcount;
      st_nxt.transit        = mid.transit + gcount;
      st_nxt.dir            = {1'b0, gside};
      st_nxt.run            = run_sum[olba_pkg::CNT_W] ? olba_pkg::CNT_MAX
                                                       : run_sum[olba_pkg::CNT_W-1:0];
    end

    res.granted_side  = gside;
    res.granted_count = gcount;
    res.direction     = st_nxt.dir;
    res.in_transit    = st_nxt.transit;
    res.error         = err;
  end

endmodule

`default_nettype wire

### rtl/one_lane_bridge_arbiter_core.sv
// ----------------------------------------------------------------------------
// One-lane bridge arbiter core
// Grants a shared one-way channel to two sides with a bounded run per side.
// ----------------------------------------------------------------------------
// The block takes one arrive or leave word per clock cycle while the result
// side is not stalled, and returns one result word for each, in order. An
// accepted event word is held in the input register; then the step logic
// updates the arbiter state and loads the result register, which drives the
// result ports. Sustained rate is one word per cycle while out_ready stays
// high; the only feedback path is the state register through the step logic.
// The result register frees the input side while a finished word waits for
// out_ready, so a stalled consumer only blocks new words once both registers
// are full. consecutive_limit is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. A value of zero acts as one.
`default_nettype none

module one_lane_bridge_arbiter_core (
  input  wire                          clk,
  input  wire                          rst_n,
  // Configuration
  input  wire                          cfg_wr_en,
  input  wire [olba_pkg::CNT_W-1:0]    cfg_wr_data,
  // Event channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_req_type,
  input  wire                          in_side,
  // Result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_granted_side,
  output logic [olba_pkg::CNT_W-1:0]   out_granted_count,
  output logic [olba_pkg::DIR_W-1:0]   out_direction,
  output logic [olba_pkg::CNT_W-1:0]   out_in_transit,
  output logic                         out_error
);

`include "one_lane_bridge_arbiter_core_assert.svh"

  logic [olba_pkg::CNT_W-1:0] limit_r;
  olba_pkg::arb_state_t       state_r;
  olba_pkg::arb_state_t       state_nxt;
  olba_pkg::result_t          res_nxt;
  olba_pkg::result_t          res_r;
  logic                       out_valid_r;
  logic                       ev_valid;
  olba_pkg::event_t           ev;
  logic                       take;

  // The held event moves on when the result register is empty or draining.
  assign take = ev_valid && (!out_valid_r || out_ready);

  olba_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_side     (in_side),
    .take        (take),
    .ev_valid    (ev_valid),
    .ev          (ev)
  );

  olba_step u_step (
    .st     (state_r),
    .limit  (limit_r),
    .ev     (ev),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= olba_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Arbiter state advances exactly once per consumed event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.dir     <= olba_pkg::DIR_NONE;
      state_r.transit <= '0;
      state_r.waiting <= '0;
      state_r.run     <= '0;
    end else if (take) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_side  = res_r.granted_side;
  assign out_granted_count = res_r.granted_count;
  assign out_direction     = res_r.direction;
  assign out_in_transit    = res_r.in_transit;
  assign out_error         = res_r.error;

  // A rejected event never admits anyone.
  `OLBA_ASSERT_SAME(a_err_no_grant, out_valid_r && res_r.error, res_r.granted_count == '0, "error result carries a grant")

  // Nobody is on the channel while it has no direction.
  `OLBA_ASSERT_SAME(a_none_empty, state_r.dir == olba_pkg::DIR_NONE, state_r.transit == '0, "users in transit with no direction")

  // The channel never holds more than its capacity.
  `OLBA_ASSERT_SAME(a_cap, 1'b1, state_r.transit <= olba_pkg::CAP_USERS, "transit count above capacity")

  // State only moves when an event is consumed.
  `OLBA_ASSERT_NEXT(a_state_hold, !take, $stable(state_r), "state changed without an event")

endmodule

`default_nettype wire
